/* hdl/dtrd_pkg.sv */
// Shared types, constants and helpers for the decimal text reduced denominator block.
// No dependencies; imported by every module under hdl/.
package dtrd_pkg;

    localparam int unsigned VALUE_W        = 60;
    localparam int unsigned COUNT_W        = 5;
    localparam int unsigned NIBBLES        = VALUE_W / 4;
    localparam int unsigned NIB_CNT_W      = $clog2(NIBBLES);
    localparam int unsigned MAX_DIGITS_DEF = 18;
    localparam int unsigned S_DATA_W       = 8;
    localparam int unsigned M_DATA_W       = ((VALUE_W + 7) / 8) * 8;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_POINT = 8'd46;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // take one character
        logic setup;      // den = 1, factor counters cleared
        logic halve;      // strip one factor of two
        logic div_start;  // load divide-by-five shifter
        logic div_step;   // one nibble of the divide
        logic div_commit; // quotient exact: strip one factor of five
        logic dbl;        // den *= 2
        logic quint;      // den *= 5
        logic emit;       // load result register, clear number state
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic bad;
        logic point;
        logic v_zero;
        logic f_zero;
        logic v_even;
        logic twos_lt;
        logic fives_lt;
        logic div_last;
        logic rem_zero;
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic [3:0] q;
        logic [2:0] r;
    } t_div5;

    // One radix-16 step of division by five: (r*16 + n) / 5 with r < 5.
    // 16r = 15r + r, so the quotient is 3r plus the quotient of (r + n).
    function automatic t_div5 div5_digit(input logic [2:0] r, input logic [3:0] n);
        logic [4:0] s;
        logic [1:0] t;
        t_div5      res;
        s = {2'b00, r} + {1'b0, n};
        if (s >= 5'd15) begin
            t = 2'd3;
        end else if (s >= 5'd10) begin
            t = 2'd2;
        end else if (s >= 5'd5) begin
            t = 2'd1;
        end else begin
            t = 2'd0;
        end
        res.q = 4'({2'b00, r} * 4'd3) + {2'b00, t};
        res.r = 3'(s - 5'({3'b000, t} * 5'd5));
        return res;
    endfunction

endpackage

/* hdl/decimal_text_reduced_denominator.sv */
// Top level of the decimal text reduced denominator block.
// Depends on dtrd_pkg, dtrd_ctrl and dtrd_datapath.
//
// Takes a decimal number as text, one character per input transfer, tlast on
// the final character, and returns one result transfer per number: the
// denominator of digits/10^fraction_digits in lowest terms, or error with a
// zero denominator for a bad character, a second point or more than
// MAX_DIGITS digits. Characters other than the last are taken one per cycle.
// The last one starts the reduction; since 10^f = 2^f * 5^f, the block strips
// factors of two from the value one per cycle (at most f), then factors of
// five with a radix-16 divide-by-five shifter, one full divide per factor
// tried (at most f tries), and rebuilds the denominator with one doubling
// or one times-five step per cycle (at most 2f). A number without a point,
// a zero value or an error skips the reduction. Input is not taken during
// reduction. A finished result sits in an output register, so the next
// number's characters stream in while it waits for the sink.
module decimal_text_reduced_denominator #(
    parameter int unsigned MAX_DIGITS = dtrd_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dtrd_pkg::S_DATA_W-1:0]   s_axis_tdata,  // [7:0] char_code
    input  logic                            s_axis_tlast,  // final_char
    // master side
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [dtrd_pkg::M_DATA_W-1:0]   m_axis_tdata,  // [59:0] denominator, rest zero
    output logic                            m_axis_tuser   // error
);
    import dtrd_pkg::*;

    t_dp_cmd            cmd;
    t_dp_status         status;
    logic [VALUE_W-1:0] den;

    dtrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dtrd_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_den       (den),
        .o_err       (m_axis_tuser)
    );

    // zero padding up to a whole byte
    assign m_axis_tdata = {{(M_DATA_W-VALUE_W){1'b0}}, den};

endmodule

/* hdl/dtrd_datapath.sv */
// Datapath: digit accumulation, factor stripping, divide-by-five shifter,
// denominator scaling and the result register. Depends on dtrd_pkg.
module dtrd_datapath #(
    parameter int unsigned MAX_DIGITS = dtrd_pkg::MAX_DIGITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [7:0]                     i_char,
    input  dtrd_pkg::t_dp_cmd              i_cmd,
    output dtrd_pkg::t_dp_status           o_status,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [dtrd_pkg::VALUE_W-1:0]   o_den,
    output logic                           o_err
);
    import dtrd_pkg::*;

    logic [VALUE_W-1:0]   r_value, n_value;
    logic                 r_point, n_point;
    logic [COUNT_W-1:0]   r_frac, n_frac;
    logic [COUNT_W-1:0]   r_total, n_total;
    logic                 r_bad, n_bad;
    logic [COUNT_W-1:0]   r_twos, n_twos;
    logic [COUNT_W-1:0]   r_fives, n_fives;
    logic [VALUE_W-1:0]   r_dvd, n_dvd;
    logic [VALUE_W-1:0]   r_quot, n_quot;
    logic [2:0]           r_rem, n_rem;
    logic [NIB_CNT_W-1:0] r_nib, n_nib;
    logic [VALUE_W-1:0]   r_den, n_den;
    logic                 r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]   r_out_den, n_out_den;
    logic                 r_out_err, n_out_err;

    t_div5                step;
    logic [3:0]           digit;

    assign step  = div5_digit(r_rem, r_dvd[VALUE_W-1 -: 4]);
    assign digit = 4'(i_char - CHAR_ZERO);

    always_comb begin
        n_value     = r_value;
        n_point     = r_point;
        n_frac      = r_frac;
        n_total     = r_total;
        n_bad       = r_bad;
        n_twos      = r_twos;
        n_fives     = r_fives;
        n_dvd       = r_dvd;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_nib       = r_nib;
        n_den       = r_den;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_den   = r_out_den;
        n_out_err   = r_out_err;

        if (i_cmd.accept && !r_bad) begin
            case (i_char) inside
                [CHAR_ZERO:CHAR_NINE]: begin
                    if (r_total >= COUNT_W'(MAX_DIGITS)) begin
                        n_bad = 1'b1;
                    end else begin
                        n_value = (r_value << 3) + (r_value << 1)
                                + {{(VALUE_W-4){1'b0}}, digit};
                        n_total = r_total + 1'b1;
                        if (r_point) begin
                            n_frac = r_frac + 1'b1;
                        end
                    end
                end
                CHAR_POINT: begin
                    if (r_point) begin
                        n_bad = 1'b1;
                    end else begin
                        n_point = 1'b1;
                    end
                end
                default: begin
                    n_bad = 1'b1;
                end
            endcase
        end

        if (i_cmd.setup) begin
            n_den   = {{(VALUE_W-1){1'b0}}, 1'b1};
            n_twos  = '0;
            n_fives = '0;
        end
        if (i_cmd.halve) begin
            n_value = r_value >> 1;
            n_twos  = r_twos + 1'b1;
        end
        if (i_cmd.div_start) begin
            n_dvd  = r_value;
            n_quot = '0;
            n_rem  = '0;
            n_nib  = '0;
        end
        if (i_cmd.div_step) begin
            n_dvd  = r_dvd << 4;
            n_quot = {r_quot[VALUE_W-5:0], step.q};
            n_rem  = step.r;
            n_nib  = r_nib + 1'b1;
        end
        if (i_cmd.div_commit) begin
            n_value = r_quot;
            n_fives = r_fives + 1'b1;
        end
        if (i_cmd.dbl) begin
            n_den  = r_den << 1;
            n_twos = r_twos + 1'b1;
        end
        if (i_cmd.quint) begin
            n_den   = (r_den << 2) + r_den;
            n_fives = r_fives + 1'b1;
        end
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_err   = r_bad;
            n_out_den   = r_bad ? '0 : r_den;
            n_value     = '0;
            n_point     = 1'b0;
            n_frac      = '0;
            n_total     = '0;
            n_bad       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value     <= '0;
            r_point     <= 1'b0;
            r_frac      <= '0;
            r_total     <= '0;
            r_bad       <= 1'b0;
            r_twos      <= '0;
            r_fives     <= '0;
            r_nib       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_value     <= n_value;
            r_point     <= n_point;
            r_frac      <= n_frac;
            r_total     <= n_total;
            r_bad       <= n_bad;
            r_twos      <= n_twos;
            r_fives     <= n_fives;
            r_nib       <= n_nib;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd     <= n_dvd;
        r_quot    <= n_quot;
        r_rem     <= n_rem;
        r_den     <= n_den;
        r_out_den <= n_out_den;
        r_out_err <= n_out_err;
    end

    always_comb begin
        o_status.bad      = r_bad;
        o_status.point    = r_point;
        o_status.v_zero   = (r_value == '0);
        o_status.f_zero   = (r_frac == '0);
        o_status.v_even   = !r_value[0];
        o_status.twos_lt  = (r_twos < r_frac);
        o_status.fives_lt = (r_fives < r_frac);
        o_status.div_last = (r_nib == NIB_CNT_W'(NIBBLES - 1));
        o_status.rem_zero = (r_rem == '0);
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_den       = r_out_den;
    assign o_err       = r_out_err;

endmodule

/* hdl/dtrd_ctrl.sv */
// Controller state machine: sequences intake, factor stripping, divide steps,
// scaling and result hand-off. Depends on dtrd_pkg.
module dtrd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_last,
    output logic                 o_in_ready,
    input  dtrd_pkg::t_dp_status i_status,
    output dtrd_pkg::t_dp_cmd    o_cmd
);
    import dtrd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_TWOS,
        S_FIVES,
        S_DIV,
        S_CHECK,
        S_SCALE,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_in_last) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                o_cmd.setup = 1'b1;
                if (i_status.bad || !i_status.point || i_status.v_zero
                        || i_status.f_zero) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_TWOS;
                end
            end
            S_TWOS: begin
                if (i_status.v_even && i_status.twos_lt) begin
                    o_cmd.halve = 1'b1;
                end else begin
                    n_state = S_FIVES;
                end
            end
            S_FIVES: begin
                if (i_status.fives_lt) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_SCALE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.rem_zero) begin
                    o_cmd.div_commit = 1'b1;
                    n_state          = S_FIVES;
                end else begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                // counters run from the stripped count up to the fraction length
                if (i_status.twos_lt) begin
                    o_cmd.dbl = 1'b1;
                end else if (i_status.fives_lt) begin
                    o_cmd.quint = 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_in_ready = r_ready;

endmodule

/* hdl/dtrd_checker.sv */
// Port-level checks for decimal_text_reduced_denominator, bound to the top level.
// Depends on dtrd_pkg.
module dtrd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [dtrd_pkg::S_DATA_W-1:0] s_axis_tdata,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [dtrd_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser
);
    import dtrd_pkg::*;

    // the final character always leaves the intake state, so intake pauses
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken right after final character");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("error result with nonzero denominator");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata != '0)
        else $error("zero denominator without error");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind decimal_text_reduced_denominator dtrd_checker u_dtrd_checker (.*);

/* test/tb_decimal_text_reduced_denominator.sv */
// Self-checking testbench for decimal_text_reduced_denominator.
// Depends on dtrd_pkg and the block itself; streams numbers as text and checks each denominator.
module tb_decimal_text_reduced_denominator;
    timeunit 1ns;
    timeprecision 1ps;

    import dtrd_pkg::*;

    // One expected result transfer
    typedef struct packed {
        logic [VALUE_W-1:0] denom;
        logic               err;
    } t_reduced;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;   // [7:0] char_code
    logic                  s_axis_tlast = 1'b0; // final_char
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;        // [59:0] denominator, rest zero
    logic                  m_axis_tuser;        // error

    // Idle rates in percent of cycles, per side
    int unsigned src_idle_pct = 20;
    int unsigned sink_idle_pct = 63;
    int unsigned mismatch_count = 0;

    // Expected denominators, oldest first
    t_reduced expected_denoms[$];

    // Predictor's copy of the number being parsed
    logic [63:0] digits_acc = '0;
    logic        point_flag = 1'b0;
    logic [4:0]  frac_count = '0;
    logic [4:0]  digit_count = '0;
    logic        number_bad = 1'b0;

    decimal_text_reduced_denominator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // Takes one character; returns 1 and the reduced denominator on the last one.
    function automatic bit predict_char(input logic [7:0] c, input logic last,
                                        output t_reduced res);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        logic [63:0] p;
        int          i;
        res = '0;
        // once an error is latched the rest of the number is ignored
        if (!number_bad) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                if (digit_count >= MAX_DIGITS_DEF) begin
                    number_bad = 1'b1;
                end else begin
                    digits_acc  = digits_acc * 64'd10 + 64'(c - CHAR_ZERO);
                    digit_count = digit_count + 5'd1;
                    if (point_flag) begin
                        frac_count = frac_count + 5'd1;
                    end
                end
            end else if (c == CHAR_POINT) begin
                if (point_flag) begin
                    number_bad = 1'b1;
                end else begin
                    point_flag = 1'b1;
                end
            end else begin
                number_bad = 1'b1;
            end
        end
        if (!last) begin
            return 1'b0;
        end
        if (number_bad) begin
            res.err = 1'b1;
        end else if (!point_flag) begin
            res.denom = VALUE_W'(1);
        end else begin
            p = 64'd1;
            for (i = 0; i < frac_count; i++) begin
                p = p * 64'd10;
            end
            // Euclid on value and 10^f; a zero value gives gcd = 10^f
            a = digits_acc;
            b = p;
            while (b != 64'd0) begin
                r = a % b;
                a = b;
                b = r;
            end
            res.denom = VALUE_W'(p / a);
        end
        digits_acc  = '0;
        point_flag  = 1'b0;
        frac_count  = '0;
        digit_count = '0;
        number_bad  = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    // Sends one character. Called at a rising edge; returns at the edge of its transfer.
    // tvalid is left high, so a back-to-back character needs only one assignment.
    task automatic send_char(input logic [7:0] c, input logic last);
        t_reduced res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= S_DATA_W'($urandom);
            s_axis_tlast  <= 1'($urandom);
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        if (predict_char(c, last, res)) begin
            expected_denoms.insert(expected_denoms.size(), res);
        end
    endtask

    task automatic send_text(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++) begin
            send_char(txt[i], i == txt.len() - 1);
        end
    endtask

    // Sink side: random backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Result checker: every result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_reduced want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_denoms.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, 64'd0);
            end else begin
                want = expected_denoms.pop_front();
                if (m_axis_tdata[VALUE_W-1:0] !== want.denom) begin
                    report_mismatch("denominator", 64'(m_axis_tdata[VALUE_W-1:0]),
                                    64'(want.denom));
                end
                if (m_axis_tdata[M_DATA_W-1:VALUE_W] !== '0) begin
                    report_mismatch("tdata padding", 64'(m_axis_tdata[M_DATA_W-1:VALUE_W]),
                                    64'd0);
                end
                if (m_axis_tuser !== want.err) begin
                    report_mismatch("error flag", 64'(m_axis_tuser), 64'(want.err));
                end
            end
        end
    end

    // Integers, a lone point, a zero value and a trailing point all give a denominator of one
    task automatic test_integers_and_points();
        send_text("7");
        send_text(".");
        send_text("0.0");
        send_text("5.");
    endtask

    // Bad characters at both ends of the code range and just outside the digits,
    // a second point, and characters after an error being ignored
    task automatic test_error_cases();
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char(CHAR_ZERO - 8'd1, 1'b1);
        send_char(CHAR_NINE + 8'd1, 1'b1);
        send_text("..");
        send_text("a5");
    endtask

    // Fractions whose reduction strips factors of two and of five
    task automatic test_fraction_reduction();
        send_text(".5");
        send_text("1.25");
        send_text(".8");
    endtask

    // Random numbers: mostly well formed, some over-long, doubled points or junk bytes
    task automatic test_random_numbers(input int n_chars, input int unsigned src_pct,
                                       input int unsigned sink_pct);
        logic [7:0]  txt[$];
        int          sent;
        int          ndig;
        int          ppos;
        int          pick;
        int          zero_bias;
        int          i;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent = 0;
        while (sent < n_chars) begin
            txt.delete();
            pick = $urandom_range(99);
            if (pick < 10) begin
                ndig = MAX_DIGITS_DEF;
            end else if (pick < 25) begin
                ndig = $urandom_range(MAX_DIGITS_DEF - 1, 9);
            end else begin
                ndig = $urandom_range(8, 1);
            end
            // ppos == ndig puts the point last, ndig + 1 leaves it out
            ppos = $urandom_range(ndig + 1, 0);
            zero_bias = $urandom_range(2, 0);
            for (i = 0; i < ndig; i++) begin
                if (i == ppos) begin
                    txt.insert(txt.size(), CHAR_POINT);
                end
                if ($urandom_range(3) < zero_bias) begin
                    txt.insert(txt.size(), CHAR_ZERO);
                end else begin
                    txt.insert(txt.size(), CHAR_ZERO + 8'($urandom_range(9)));
                end
            end
            if (ppos == ndig) begin
                txt.insert(txt.size(), CHAR_POINT);
            end
            pick = $urandom_range(99);
            if (pick < 6) begin
                // run past the digit limit by one to three digits
                for (i = ndig; i < MAX_DIGITS_DEF + $urandom_range(3, 1); i++) begin
                    txt.insert(txt.size(), CHAR_ZERO + 8'($urandom_range(9)));
                end
            end else if (pick < 10) begin
                txt.insert($urandom_range(txt.size()), CHAR_POINT);
            end else if (pick < 14) begin
                txt[$urandom_range(txt.size() - 1)] = 8'($urandom);
            end else if (pick < 17) begin
                txt.delete();
                for (i = 0; i < $urandom_range(4, 1); i++) begin
                    txt.insert(txt.size(), 8'($urandom));
                end
            end
            for (i = 0; i < txt.size(); i++) begin
                send_char(txt[i], i == txt.size() - 1);
            end
            sent += txt.size();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_integers_and_points();
        test_error_cases();
        test_fraction_reduction();
        test_random_numbers(600, 20, 63);
        test_random_numbers(600, 63, 20);
        test_random_numbers(600, 0, 0);
        s_axis_tvalid <= 1'b0;
        while (expected_denoms.size() != 0) begin
            @(posedge i_clk);
        end
        // wait on to catch stray results
        repeat (450) @(posedge i_clk);
        if (expected_denoms.size() != 0) begin
            report_mismatch("missing results", 64'(expected_denoms.size()), 64'd0);
        end
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
hdl/dtrd_pkg.sv
hdl/dtrd_datapath.sv
hdl/dtrd_ctrl.sv
hdl/decimal_text_reduced_denominator.sv
hdl/dtrd_checker.sv
test/tb_decimal_text_reduced_denominator.sv
